>>> design/piecewise_bezier_path_evaluator_defines.svh
// Assertion macros shared by the path evaluator checker.
// No dependencies; included by bare file name.
`ifndef PIECEWISE_BEZIER_PATH_EVALUATOR_DEFINES_SVH
`define PIECEWISE_BEZIER_PATH_EVALUATOR_DEFINES_SVH

// same-cycle implication
`define BPE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpe assertion failed");

// next-cycle implication
`define BPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpe assertion failed");

`endif

>>> design/bpe_pkg.sv
// Shared types and constants for the piecewise Bezier path evaluator.
// No dependencies.
package bpe_pkg;

   localparam int COEF_W  = 19;   // signed width of basis coefficients
   localparam int FRAC_W  = 16;   // Q16.16 fraction bits
   localparam int PARAM_W = 17;   // p in [0, 1.0]

   localparam logic       KIND_WRITE = 1'b0;
   localparam logic       KIND_EVAL  = 1'b1;

   localparam logic [3:0] COMP_END     = 4'd0;
   localparam logic [3:0] COMP_ANCHOR0 = 4'd1;
   localparam logic [3:0] COMP_ANCHOR2 = 4'd3;
   localparam logic [3:0] COMP_NEAR0   = 4'd4;
   localparam logic [3:0] COMP_NEAR2   = 4'd6;
   localparam logic [3:0] COMP_FAR0    = 4'd7;
   localparam logic [3:0] COMP_FAR2    = 4'd9;

   localparam logic [2:0] REG_SEGMENT_COUNT = 3'd0;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_SCANRD = 11'b000_0000_0010,
      ST_SCAN   = 11'b000_0000_0100,
      ST_PREP   = 11'b000_0000_1000,
      ST_DIV    = 11'b000_0001_0000,
      ST_BASIS  = 11'b000_0010_0000,
      ST_LOAD   = 11'b000_0100_0000,
      ST_COORD  = 11'b000_1000_0000,
      ST_SUM1   = 11'b001_0000_0000,
      ST_SUM2   = 11'b010_0000_0000,
      ST_FINISH = 11'b100_0000_0000
   } state_type;

endpackage

>>> design/piecewise_bezier_path_evaluator.sv
// Piecewise cubic Bezier path evaluator, top level: table memories and sequencer.
// Depends on bpe_pkg and bpe_mul.
// Write transaction: taken while idle, no result; the block stays ready.
// Evaluate: a read and a compare per scanned segment (up to MAX_SEGMENTS), the
// restoring divider when needed, the basis, then each axis in turn on the one multiplier,
// then the result is posted. Not ready while an evaluation runs.
// Synchronous active-high reset clears control state and sets segment_count to 1.
module piecewise_bezier_path_evaluator #(
   parameter int MAX_SEGMENTS = 64,
   parameter int COORD_BITS   = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,   // node[6:0], component[10:7], value[42:11],
                                     // query_time[73:43], zero pad
   input  logic [0:0]   req_tuser,   // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [199:0] rsp_tdata,   // pos_x, pos_y, pos_z, tan_x, tan_y, tan_z (32 each),
                                     // segment[197:192], zero pad
   output logic [1:0]   rsp_tuser,   // clamped, zero_interval
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   localparam int IW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int AW  = $clog2(3 * (MAX_SEGMENTS + 1));
   localparam int CW3 = $clog2(3 * MAX_SEGMENTS);
   localparam int BW  = (COORD_BITS > bpe_pkg::COEF_W) ? COORD_BITS : bpe_pkg::COEF_W;
   localparam int VW  = (COORD_BITS > 32) ? COORD_BITS : 32;
   localparam int CF  = bpe_pkg::COEF_W;

   // request fields
   logic [6:0]         req_node;
   logic [3:0]         req_comp;
   logic signed [31:0] req_value;
   logic [30:0]        req_time;
   assign req_node  = req_tdata[6:0];
   assign req_comp  = req_tdata[10:7];
   assign req_value = req_tdata[42:11];
   assign req_time  = req_tdata[73:43];

   bpe_pkg::state_type state_ff, state_in;

   logic [6:0]  count_ff;
   logic [3:0]  step_ff, step_in;
   logic [1:0]  axis_ff, axis_in;
   logic [1:0]  load_ff, load_in;
   logic [IW-1:0] idx_ff, idx_in, last_idx;

   logic signed [32:0] t_ff, t_in, prev_ff, prev_in, cur_ff, cur_in;
   logic [32:0] rem_ff, rem_in, den_ff, den_in;
   logic [bpe_pkg::PARAM_W-1:0] p_ff, p_in;
   logic clamp_ff, clamp_in, zero_ff, zero_in;

   logic signed [CF-1:0] p2_ff, p2_in, ip2_ff, ip2_in, p3_ff, p3_in, ip3_ff, ip3_in;
   logic signed [CF-1:0] b1_ff, b1_in, b2_ff, b2_in, cq_ff, cq_in, cr_ff, cr_in;
   logic signed [CF-1:0] pq, ipq;

   logic signed [COORD_BITS-1:0] a0_ff, a0_in, a1_ff, a1_in, cn_ff, cn_in, cf_ff, cf_in;
   logic signed [COORD_BITS-1:0] prod_ff [8];
   logic signed [COORD_BITS-1:0] prod_in [8];
   logic signed [COORD_BITS-1:0] pos_ff [3];
   logic signed [COORD_BITS-1:0] pos_in [3];
   logic signed [COORD_BITS-1:0] tan_ff [3];
   logic signed [COORD_BITS-1:0] tan_in [3];

   logic         rsp_valid_ff, rsp_valid_in;
   logic [199:0] rsp_data_ff, rsp_data_in;
   logic [1:0]   rsp_user_ff, rsp_user_in;

   // memories
   logic signed [31:0]           end_mem    [MAX_SEGMENTS];
   logic signed [COORD_BITS-1:0] anchor_mem [3 * (MAX_SEGMENTS + 1)];
   logic signed [COORD_BITS-1:0] near_mem   [3 * MAX_SEGMENTS];
   logic signed [COORD_BITS-1:0] far_mem    [3 * MAX_SEGMENTS];
   logic signed [31:0]           end_rd_ff;
   logic signed [COORD_BITS-1:0] anchor_rd_ff, near_rd_ff, far_rd_ff;

   logic          wr_ok, accept;
   logic [AW-1:0] anchor_wa, anchor_ra;
   logic [CW3-1:0] ctrl_wa, ctrl_ra;
   logic signed [COORD_BITS-1:0] wr_sat;

   // shared multiplier
   logic signed [CF-1:0]         mul_coef;
   logic signed [BW-1:0]         mul_coord;
   logic signed [COORD_BITS-1:0] mul_sat;
   logic signed [CF-1:0]         mul_raw;

   bpe_mul #(.COORD_BITS(COORD_BITS)) u_mul (
      .clock (clock),
      .coef  (mul_coef),
      .coord (mul_coord),
      .q_sat (mul_sat),
      .q_raw (mul_raw)
   );

   function automatic logic signed [COORD_BITS-1:0] sadd(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b
   );
      logic signed [COORD_BITS:0] s;
      s = (COORD_BITS+1)'(a) + (COORD_BITS+1)'(b);
      if (s[COORD_BITS] != s[COORD_BITS-1]) begin
         return s[COORD_BITS] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                              : {1'b0, {(COORD_BITS-1){1'b1}}};
      end
      return s[COORD_BITS-1:0];
   endfunction

   // value saturated to coordinate width on write
   always_comb begin
      logic signed [VW-1:0] v;
      v = VW'(req_value);
      if ((&v[VW-1:COORD_BITS-1]) | ~(|v[VW-1:COORD_BITS-1])) begin
         wr_sat = v[COORD_BITS-1:0];
      end else if (v[VW-1]) begin
         wr_sat = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
         wr_sat = {1'b0, {(COORD_BITS-1){1'b1}}};
      end
   end

   assign req_tready = (state_ff == bpe_pkg::ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      wr_ok = accept && (req_tuser[0] == bpe_pkg::KIND_WRITE)
              && (int'(req_node) <= MAX_SEGMENTS) && (req_comp <= bpe_pkg::COMP_FAR2);
      // final node carries an anchor only
      if (int'(req_node) == MAX_SEGMENTS
          && !(req_comp inside {[bpe_pkg::COMP_ANCHOR0 : bpe_pkg::COMP_ANCHOR2]})) begin
         wr_ok = 1'b0;
      end
   end

   always_comb begin
      case (req_comp) inside
         [bpe_pkg::COMP_ANCHOR0 : bpe_pkg::COMP_ANCHOR2]:
            ctrl_wa = CW3'(int'(req_node) * 3 + int'(req_comp) - int'(bpe_pkg::COMP_ANCHOR0));
         [bpe_pkg::COMP_NEAR0 : bpe_pkg::COMP_NEAR2]:
            ctrl_wa = CW3'(int'(req_node) * 3 + int'(req_comp) - int'(bpe_pkg::COMP_NEAR0));
         default:
            ctrl_wa = CW3'(int'(req_node) * 3 + int'(req_comp) - int'(bpe_pkg::COMP_FAR0));
      endcase
      anchor_wa = AW'(int'(req_node) * 3 + int'(req_comp) - int'(bpe_pkg::COMP_ANCHOR0));
      anchor_ra = AW'((int'(idx_ff) + ((load_ff == 2'd0) ? 0 : 1)) * 3 + int'(axis_ff));
      ctrl_ra   = CW3'(int'(idx_ff) * 3 + int'(axis_ff));
   end

   always_ff @(posedge clock) begin
      if (wr_ok && req_comp == bpe_pkg::COMP_END) begin
         end_mem[IW'(req_node)] <= req_value;
      end
      end_rd_ff <= end_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (wr_ok && (req_comp inside {[bpe_pkg::COMP_ANCHOR0 : bpe_pkg::COMP_ANCHOR2]})) begin
         anchor_mem[anchor_wa] <= wr_sat;
      end
      anchor_rd_ff <= anchor_mem[anchor_ra];
   end

   always_ff @(posedge clock) begin
      if (wr_ok && (req_comp inside {[bpe_pkg::COMP_NEAR0 : bpe_pkg::COMP_NEAR2]})) begin
         near_mem[ctrl_wa] <= wr_sat;
      end
      near_rd_ff <= near_mem[ctrl_ra];
   end

   always_ff @(posedge clock) begin
      if (wr_ok && (req_comp inside {[bpe_pkg::COMP_FAR0 : bpe_pkg::COMP_FAR2]})) begin
         far_mem[ctrl_wa] <= wr_sat;
      end
      far_rd_ff <= far_mem[ctrl_ra];
   end

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == bpe_pkg::REG_SEGMENT_COUNT) ? {25'd0, count_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 7'd1;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr == bpe_pkg::REG_SEGMENT_COUNT) begin
         count_ff <= csr_pwdata[6:0];
      end
   end

   always_comb begin
      if (count_ff == 7'd0) begin
         last_idx = '0;
      end else if (int'(count_ff) > MAX_SEGMENTS) begin
         last_idx = IW'(MAX_SEGMENTS - 1);
      end else begin
         last_idx = IW'(count_ff - 7'd1);
      end
   end

   assign pq  = CF'(p_ff);
   assign ipq = CF'(32'sd65536) - pq;

   // multiplier operand selection
   always_comb begin
      mul_coef  = pq;
      mul_coord = BW'(pq);
      if (state_ff == bpe_pkg::ST_BASIS) begin
         case (step_ff[3:1])
            3'd0: begin mul_coef = pq;           mul_coord = BW'(pq);     end
            3'd1: begin mul_coef = ipq;          mul_coord = BW'(ipq);    end
            3'd2: begin mul_coef = pq;           mul_coord = BW'(p2_ff);  end
            3'd3: begin mul_coef = ipq;          mul_coord = BW'(ip2_ff); end
            3'd4: begin mul_coef = ip2_ff;       mul_coord = BW'(pq);     end
            3'd5: begin mul_coef = p2_ff;        mul_coord = BW'(ipq);    end
            3'd6: begin mul_coef = -(ipq <<< 1); mul_coord = BW'(pq);     end
            default: begin mul_coef = ipq <<< 1; mul_coord = BW'(pq);     end
         endcase
      end else begin
         case (step_ff[3:1])
            3'd0: begin mul_coef = ip3_ff;  mul_coord = BW'(a0_ff); end
            3'd1: begin mul_coef = p3_ff;   mul_coord = BW'(a1_ff); end
            3'd2: begin mul_coef = b2_ff;   mul_coord = BW'(cf_ff); end
            3'd3: begin mul_coef = b1_ff;   mul_coord = BW'(cn_ff); end
            3'd4: begin mul_coef = -ip2_ff; mul_coord = BW'(a0_ff); end
            3'd5: begin mul_coef = p2_ff;   mul_coord = BW'(a1_ff); end
            3'd6: begin mul_coef = cq_ff;   mul_coord = BW'(cn_ff); end
            default: begin mul_coef = cr_ff; mul_coord = BW'(cf_ff); end
         endcase
      end
   end

   // sequencer
   always_comb begin
      logic signed [33:0] span, tl;
      logic [33:0]        span_m, tl_m, rem2;
      state_in = state_ff;
      step_in  = step_ff;
      axis_in  = axis_ff;
      load_in  = load_ff;
      idx_in   = idx_ff;
      t_in     = t_ff;
      prev_in  = prev_ff;
      cur_in   = cur_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      p_in     = p_ff;
      clamp_in = clamp_ff;
      zero_in  = zero_ff;
      p2_in = p2_ff; ip2_in = ip2_ff; p3_in = p3_ff; ip3_in = ip3_ff;
      b1_in = b1_ff; b2_in = b2_ff;   cq_in = cq_ff; cr_in = cr_ff;
      a0_in = a0_ff; a1_in = a1_ff;   cn_in = cn_ff; cf_in = cf_ff;
      prod_in = prod_ff;
      pos_in  = pos_ff;
      tan_in  = tan_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      span   = 34'(cur_ff) - 34'(prev_ff);
      tl     = 34'(t_ff) - 34'(prev_ff);
      span_m = span[33] ? 34'(-span) : 34'(span);
      tl_m   = tl[33] ? 34'(-tl) : 34'(tl);
      rem2   = {rem_ff, 1'b0};

      case (state_ff)
         bpe_pkg::ST_IDLE: begin
            if (accept && req_tuser[0] == bpe_pkg::KIND_EVAL) begin
               t_in     = 33'(req_time);
               prev_in  = '0;
               idx_in   = '0;
               clamp_in = 1'b0;
               state_in = bpe_pkg::ST_SCANRD;
            end
         end
         bpe_pkg::ST_SCANRD: state_in = bpe_pkg::ST_SCAN;
         bpe_pkg::ST_SCAN: begin
            if (33'(end_rd_ff) >= t_ff) begin
               cur_in   = 33'(end_rd_ff);
               state_in = bpe_pkg::ST_PREP;
            end else if (idx_ff == last_idx) begin
               // past the last end: clamp time to it
               cur_in   = 33'(end_rd_ff);
               t_in     = 33'(end_rd_ff);
               clamp_in = 1'b1;
               state_in = bpe_pkg::ST_PREP;
            end else begin
               prev_in  = 33'(end_rd_ff);
               idx_in   = idx_ff + 1'b1;
               state_in = bpe_pkg::ST_SCANRD;
            end
         end
         bpe_pkg::ST_PREP: begin
            zero_in  = (span == 34'sd0);
            p_in     = '0;
            step_in  = '0;
            state_in = bpe_pkg::ST_BASIS;
            if (span == 34'sd0 || tl == 34'sd0 || span[33] != tl[33]) begin
               p_in = '0;
            end else if (tl_m >= span_m) begin
               p_in = bpe_pkg::PARAM_W'(32'd65536);
            end else begin
               rem_in   = tl_m[32:0];
               den_in   = span_m[32:0];
               state_in = bpe_pkg::ST_DIV;
            end
         end
         bpe_pkg::ST_DIV: begin
            // one quotient bit per cycle
            if (rem2 >= {1'b0, den_ff}) begin
               rem_in = 33'(rem2 - {1'b0, den_ff});
               p_in   = {p_ff[bpe_pkg::PARAM_W-2:0], 1'b1};
            end else begin
               rem_in = rem2[32:0];
               p_in   = {p_ff[bpe_pkg::PARAM_W-2:0], 1'b0};
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd15) begin
               step_in  = '0;
               state_in = bpe_pkg::ST_BASIS;
            end
         end
         bpe_pkg::ST_BASIS: begin
            step_in = step_ff + 4'd1;
            if (step_ff[0]) begin
               case (step_ff[3:1])
                  3'd0: p2_in  = mul_raw;
                  3'd1: ip2_in = mul_raw;
                  3'd2: p3_in  = mul_raw;
                  3'd3: ip3_in = mul_raw;
                  3'd4: b1_in  = (mul_raw <<< 1) + mul_raw;
                  3'd5: b2_in  = (mul_raw <<< 1) + mul_raw;
                  3'd6: cq_in  = mul_raw + ip2_ff;
                  default: cr_in = mul_raw - p2_ff;
               endcase
               if (step_ff == 4'd15) begin
                  step_in  = '0;
                  axis_in  = '0;
                  load_in  = '0;
                  state_in = bpe_pkg::ST_LOAD;
               end
            end
         end
         bpe_pkg::ST_LOAD: begin
            // start anchor, near and far read first, end anchor next
            load_in = load_ff + 2'd1;
            if (load_ff == 2'd1) begin
               a0_in = anchor_rd_ff;
               cn_in = near_rd_ff;
               cf_in = far_rd_ff;
            end else if (load_ff == 2'd2) begin
               a1_in    = anchor_rd_ff;
               load_in  = '0;
               step_in  = '0;
               state_in = bpe_pkg::ST_COORD;
            end
         end
         bpe_pkg::ST_COORD: begin
            step_in = step_ff + 4'd1;
            if (step_ff[0]) begin
               prod_in[step_ff[3:1]] = mul_sat;
               if (step_ff == 4'd15) begin
                  step_in  = '0;
                  state_in = bpe_pkg::ST_SUM1;
               end
            end
         end
         bpe_pkg::ST_SUM1: begin
            prod_in[0] = sadd(prod_ff[0], prod_ff[1]);
            prod_in[1] = sadd(prod_ff[2], prod_ff[3]);
            prod_in[2] = sadd(prod_ff[4], prod_ff[5]);
            prod_in[3] = sadd(prod_ff[6], prod_ff[7]);
            state_in   = bpe_pkg::ST_SUM2;
         end
         bpe_pkg::ST_SUM2: begin
            pos_in[axis_ff] = sadd(prod_ff[0], prod_ff[1]);
            tan_in[axis_ff] = sadd(prod_ff[2], prod_ff[3]);
            if (axis_ff == 2'd2) begin
               state_in = bpe_pkg::ST_FINISH;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = bpe_pkg::ST_LOAD;
            end
         end
         bpe_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, 6'(idx_ff),
                               32'(tan_ff[2]), 32'(tan_ff[1]), 32'(tan_ff[0]),
                               32'(pos_ff[2]), 32'(pos_ff[1]), 32'(pos_ff[0])};
               rsp_user_in  = {zero_ff, clamp_ff};
               state_in     = bpe_pkg::ST_IDLE;
            end
         end
         default: state_in = bpe_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpe_pkg::ST_IDLE;
         step_ff      <= '0;
         axis_ff      <= '0;
         load_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         axis_ff      <= axis_in;
         load_ff      <= load_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in;     prev_ff <= prev_in; cur_ff <= cur_in;
      rem_ff <= rem_in; den_ff <= den_in;   p_ff <= p_in;
      clamp_ff <= clamp_in; zero_ff <= zero_in;
      p2_ff <= p2_in;  ip2_ff <= ip2_in; p3_ff <= p3_in; ip3_ff <= ip3_in;
      b1_ff <= b1_in;  b2_ff <= b2_in;   cq_ff <= cq_in; cr_ff <= cr_in;
      a0_ff <= a0_in;  a1_ff <= a1_in;   cn_ff <= cn_in; cf_ff <= cf_in;
      prod_ff <= prod_in;
      pos_ff  <= pos_in;
      tan_ff  <= tan_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

>>> design/bpe_mul.sv
// Shared signed multiplier with registered product, Q16.16 floor and saturation.
// Depends on bpe_pkg.
module bpe_mul #(
   parameter int COORD_BITS = 32
) (
   input  logic                                  clock,
   input  logic signed [bpe_pkg::COEF_W-1:0]     coef,
   input  logic signed [((COORD_BITS > bpe_pkg::COEF_W) ? COORD_BITS
                         : bpe_pkg::COEF_W)-1:0] coord,
   output logic signed [COORD_BITS-1:0]          q_sat,
   output logic signed [bpe_pkg::COEF_W-1:0]     q_raw
);
   localparam int BW = (COORD_BITS > bpe_pkg::COEF_W) ? COORD_BITS : bpe_pkg::COEF_W;
   localparam int PW = BW + bpe_pkg::COEF_W;
   localparam int FW = PW - bpe_pkg::FRAC_W;

   logic signed [PW-1:0] prod_ff;
   logic signed [PW-1:0] prod_in;
   logic signed [FW-1:0] floor_q;
   logic                 fits;

   assign prod_in = PW'(coef) * PW'(coord);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // arithmetic shift gives floor division by 65536
   assign floor_q = FW'(prod_ff >>> bpe_pkg::FRAC_W);
   assign fits    = (&floor_q[FW-1:COORD_BITS-1]) | ~(|floor_q[FW-1:COORD_BITS-1]);
   assign q_raw   = floor_q[bpe_pkg::COEF_W-1:0];

   always_comb begin
      if (fits) begin
         q_sat = floor_q[COORD_BITS-1:0];
      end else if (floor_q[FW-1]) begin
         q_sat = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
         q_sat = {1'b0, {(COORD_BITS-1){1'b1}}};
      end
   end

endmodule

>>> design/bpe_checker.sv
// Port-level checker for the path evaluator, bound to the top level.
// Depends on piecewise_bezier_path_evaluator_defines.svh.
`include "piecewise_bezier_path_evaluator_defines.svh"

module bpe_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [0:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [199:0] rsp_tdata,
   input logic [1:0]   rsp_tuser,
   input logic         csr_pready
);
   // a stalled result holds
   `BPE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   // evaluation occupies the block
   `BPE_ASSERT_NEXT(a_eval_busy, clock, reset, req_tvalid && req_tready && req_tuser[0], !req_tready)
   // a table write finishes in its own cycle
   `BPE_ASSERT_NEXT(a_write_quick, clock, reset, req_tvalid && req_tready && !req_tuser[0], req_tready)
   `BPE_ASSERT_IMPL(a_pready, clock, reset, 1'b1, csr_pready)
endmodule

bind piecewise_bezier_path_evaluator bpe_checker u_bpe_checker (.*);
